// ===== sv/ftprp_pkg.sv =====
// shared types and constants of the ftp reply parser
package ftprp_pkg;

	localparam int unsigned MSG_CAP = 1024;
	localparam int unsigned TEXT_W = $clog2(MSG_CAP);

	localparam logic [TEXT_W-1:0] TEXT_MAX = TEXT_W'(MSG_CAP - 1);

	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HYPHEN = 8'h2d;
	localparam logic [7:0] CH_NL     = 8'h0a;

	localparam logic [1:0] PH_START  = 2'd0;
	localparam logic [1:0] PH_SINGLE = 2'd1;
	localparam logic [1:0] PH_MULTI  = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       link_closed;
	} ftprp_in_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       is_text;
		logic       reply_done;
		logic [9:0] reply_code;
		logic       text_truncated;
		logic       ended_by_close;
	} ftprp_out_t;

endpackage

// ===== sv/ftprp_if.sv =====
// valid/ready channel interfaces for input bytes and results
interface ftprp_in_if import ftprp_pkg::*; ();
	logic      valid;
	logic      ready;
	ftprp_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ftprp_out_if import ftprp_pkg::*; ();
	logic       valid;
	logic       ready;
	ftprp_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ftprp_parse.sv =====
// parse state and per-byte decision logic
module ftprp_parse import ftprp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  ftprp_in_t  item,
	output logic       res_valid,
	output ftprp_out_t res
);

	logic [1:0]        phase_q, phase_d;
	logic [3:0]        digit_q [3];
	logic [3:0]        digit_d [3];
	logic [1:0]        dcount_q, dcount_d;
	logic [2:0]        la_count_q, la_count_d;
	logic              la_match_q, la_match_d;
	logic [TEXT_W-1:0] text_count_q, text_count_d;
	logic              overflow_q, overflow_d;

	logic              finish;
	logic              by_close;
	logic [9:0]        code;
	logic [1:0]        la_pos;
	logic [7:0]        b;
	logic [7:0]        expect_ch;

	assign b = item.rx_byte;
	assign la_pos = 2'(la_count_q - 3'd1);
	assign expect_ch = CH_ZERO + {4'd0, digit_q[la_pos]};

	always_comb begin
		code = '0;
		if (dcount_q == 2'd3) begin
			code = 10'(digit_q[0]) * 10'd100 + 10'(digit_q[1]) * 10'd10
				+ 10'(digit_q[2]);
		end
	end

	always_comb begin
		phase_d = phase_q;
		digit_d = digit_q;
		dcount_d = dcount_q;
		la_count_d = la_count_q;
		la_match_d = la_match_q;
		text_count_d = text_count_q;
		overflow_d = overflow_q;
		finish = 1'b0;
		by_close = 1'b0;
		res_valid = 1'b0;
		res = '0;

		if (item.link_closed) begin
			finish = 1'b1;
			by_close = 1'b1;
		end else begin
			unique case (phase_q)
				PH_SINGLE: begin
					if (b == CH_NL) begin
						finish = 1'b1;
					end else if (text_count_q < TEXT_MAX) begin
						text_count_d = text_count_q + TEXT_W'(1);
						res_valid = 1'b1;
						res.text_byte = b;
						res.is_text = 1'b1;
					end else begin
						overflow_d = 1'b1;
					end
				end
				PH_MULTI: begin
					if (la_count_q != 3'd0) begin
						if (la_count_q <= 3'd3) begin
							if (dcount_q != 2'd3 || b != expect_ch) begin
								la_match_d = 1'b0;
							end
							la_count_d = la_count_q + 3'd1;
						end else begin
							if (la_match_q && b == CH_SPACE) begin
								phase_d = PH_SINGLE;
							end
							la_count_d = 3'd0;
							la_match_d = 1'b1;
						end
					end else if (b == CH_NL) begin
						la_count_d = 3'd1;
						la_match_d = 1'b1;
					end
				end
				default: begin
					// start mode, unused code behaves the same
					if (dcount_q < 2'd3 && b >= CH_ZERO && b <= CH_NINE) begin
						digit_d[dcount_q] = 4'(b - CH_ZERO);
						dcount_d = dcount_q + 2'd1;
					end else if (b == CH_SPACE) begin
						phase_d = PH_SINGLE;
					end else if (b == CH_HYPHEN) begin
						phase_d = PH_MULTI;
					end else if (b == CH_NL) begin
						finish = 1'b1;
					end
				end
			endcase
		end

		if (finish) begin
			res_valid = 1'b1;
			res = '0;
			res.reply_done = 1'b1;
			res.reply_code = code;
			res.text_truncated = overflow_q;
			res.ended_by_close = by_close;
			// rearm for the next reply
			phase_d = PH_START;
			digit_d[0] = '0;
			digit_d[1] = '0;
			digit_d[2] = '0;
			dcount_d = '0;
			la_count_d = '0;
			la_match_d = 1'b1;
			text_count_d = '0;
			overflow_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			digit_q[0] <= '0;
			digit_q[1] <= '0;
			digit_q[2] <= '0;
			dcount_q <= '0;
			la_count_q <= '0;
			la_match_q <= 1'b1;
			text_count_q <= '0;
			overflow_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			digit_q <= digit_d;
			dcount_q <= dcount_d;
			la_count_q <= la_count_d;
			la_match_q <= la_match_d;
			text_count_q <= text_count_d;
			overflow_q <= overflow_d;
		end
	end

endmodule

// ===== sv/ftp_reply_parser.sv =====
// ftp reply parser top level: input register, parse stage, result register
// Takes one control-channel byte per cycle and returns at most one result per byte: a
// message byte of the final reply line, or a done result with the three-digit reply code.
// A byte accepted into the input register is decoded and its result registered when the
// parse stage advances. The block sustains one byte per cycle; the single parse stage
// between the input register and the result register sets that figure, and the input side
// stalls only while a result waits at the output and the input register is also full.
module ftp_reply_parser import ftprp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	ftprp_in_if.sink           rx,
	ftprp_out_if.source        reply
);

	logic       valid_s1;
	ftprp_in_t  item_s1;
	logic       advance;
	logic       res_valid;
	ftprp_out_t res;
	logic       reply_valid_q;
	ftprp_out_t reply_data_q;

	assign advance = valid_s1 && (!reply_valid_q || reply.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			item_s1 <= rx.data;
		end
	end

	ftprp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_valid_q <= 1'b0;
		end else if (advance) begin
			reply_valid_q <= res_valid;
		end else if (reply.ready) begin
			reply_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			reply_data_q <= res;
		end
	end

	assign reply.valid = reply_valid_q;
	assign reply.data = reply_data_q;

endmodule

// ===== sv/ftprp_checker.sv =====
// port-level assertions for the ftp reply parser and their bind
module ftprp_checker import ftprp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       reply_valid,
	input logic       reply_ready,
	input ftprp_out_t reply_data
);

	// a stalled result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && !reply_ready |=> reply_valid && $stable(reply_data))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid |-> (reply_data.is_text ^ reply_data.reply_done))
		else $error("result is neither text nor done, or both");

	a_text_clean: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply_data.is_text |-> reply_data.reply_code == 10'd0
			&& !reply_data.text_truncated && !reply_data.ended_by_close)
		else $error("text result carries done fields");

	a_done_byte: assert property (@(posedge clk) disable iff (!arst_n)
		reply_valid && reply_data.reply_done |-> reply_data.text_byte == 8'd0
			&& reply_data.reply_code <= 10'd999)
		else $error("done result has stray byte or bad code");

endmodule

bind ftp_reply_parser ftprp_checker u_ftprp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.reply_valid (reply.valid),
	.reply_ready (reply.ready),
	.reply_data  (reply.data)
);
